@@ sv/rvcs_pkg.sv @@
// Shared constants and types of the rule vote class scorer.
package rvcs_pkg;
    localparam int NUM_CLASSES = 4;
    localparam int MAX_RULES   = 1024;
    localparam int COST_W      = 16;
    localparam int CONF_W      = 17;
    localparam int SUM_W       = 27;
    localparam int CNT_W       = 11;
    localparam int PROD_W      = COST_W + SUM_W;
    localparam int TOTAL_W     = PROD_W + 2;
    localparam int SCORE_W     = 17;
    localparam int LABEL_W     = 2;
    localparam logic [CONF_W-1:0] CONF_ONE  = 17'd65536;
    localparam logic [COST_W-1:0] COST_INIT = 16'd256;

    typedef logic [COST_W-1:0]  t_cost;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [PROD_W-1:0]  t_raw;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [SCORE_W-1:0] t_score;
endpackage

@@ sv/rule_vote_class_scorer.sv @@
// Top level: per-class vote accumulation, bit-serial scoring and ranking.
//
// Channel   Direction  Handshake                   Payload
// command   in         start && !busy              vote_present, rule_label, confidence, last
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
// result    out        o_valid, one cycle each     class_index, score, ranked_label, final
//
// A request without last_rule is taken every cycle (busy stays low).
// A request with last_rule starts scoring: per class 16 multiply steps and 43
// divide steps of the bit-serial unit, then 17 normalize steps per class, then
// one result per cycle for the four classes.
// Synchronous active-low reset restores costs to 1.0 and clears the sums.
// Results cannot be stalled; they are shown once, one cycle each.
module rule_vote_class_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_vote_present,
    input  logic [rvcs_pkg::LABEL_W-1:0]  i_rule_label,
    input  logic [rvcs_pkg::CONF_W-1:0]   i_rule_confidence,
    input  logic                          i_last_rule,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [rvcs_pkg::COST_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic [rvcs_pkg::LABEL_W-1:0]  o_class_index,
    output logic [rvcs_pkg::SCORE_W-1:0]  o_class_score,
    output logic [rvcs_pkg::LABEL_W-1:0]  o_ranked_label,
    output logic                          o_final_result
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam int NC = rvcs_pkg::NUM_CLASSES;
    localparam int PW = rvcs_pkg::PROD_W;
    localparam int TW = rvcs_pkg::TOTAL_W;

    logic [2:0]             r_state;
    logic [5:0]             r_cnt;
    logic [1:0]             r_cls;
    logic [NC-1:0]          r_taken;
    rvcs_pkg::t_cost        r_cost  [4];
    rvcs_pkg::t_sum         r_sum   [NC];
    rvcs_pkg::t_count       r_count [NC];
    rvcs_pkg::t_raw         r_raw   [NC];
    rvcs_pkg::t_score       r_norm  [NC];
    rvcs_pkg::t_raw         r_prod;
    logic [11:0]            r_rem;
    logic [TW:0]            r_nrem;
    rvcs_pkg::t_score       r_q;
    rvcs_pkg::t_total       r_total;

    logic                   accept;
    logic [rvcs_pkg::CONF_W-1:0] conf_clamp;
    logic [rvcs_pkg::SUM_W:0]    sum_add;
    logic [11:0]            div_sh;
    logic [11:0]            div_d;
    logic                   div_ge;
    logic [TW:0]            norm_sh;
    logic                   norm_ge;
    logic [1:0]             best;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Clamped confidence and saturating sum for the voted class
    always_comb begin
        conf_clamp = (i_rule_confidence > rvcs_pkg::CONF_ONE) ? rvcs_pkg::CONF_ONE
                                                             : i_rule_confidence;
        sum_add = {1'b0, r_sum[i_rule_label]}
                + {{(rvcs_pkg::SUM_W + 1 - rvcs_pkg::CONF_W){1'b0}}, conf_clamp};
    end

    // Restoring divide step by count + 1
    always_comb begin
        div_sh = {r_rem[10:0], r_prod[PW-1]};
        div_d  = {1'b0, r_count[r_cls]} + 12'd1;
        div_ge = (div_sh >= div_d);
    end

    // Normalize step: raw * 2^16 / total, one quotient bit per cycle
    always_comb begin
        norm_sh = (r_cnt == 6'd0) ? {{(TW + 1 - PW){1'b0}}, r_raw[r_cls]}
                                  : {r_nrem[TW-1:0], 1'b0};
        norm_ge = (norm_sh >= {1'b0, r_total});
    end

    // Best untaken class, ties to the lower index
    always_comb begin
        logic found;
        found = 1'b0;
        best  = 2'd0;
        for (int j = 0; j < NC; j++) begin
            if (!r_taken[j] && (!found || r_norm[j] > r_norm[best])) begin
                best  = 2'(j);
                found = 1'b1;
            end
        end
    end

    // Cost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_cost[i] <= rvcs_pkg::COST_INIT;
        end else if (i_cfg_we) begin
            r_cost[i_cfg_index] <= i_cfg_data;
        end
    end

    // Sequencer, accumulators and serial arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cls   <= '0;
            r_taken <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < NC; i++) begin
                r_sum[i]   <= '0;
                r_count[i] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_vote_present && (32'(i_rule_label) < NC)
                            && (32'(r_count[i_rule_label]) < rvcs_pkg::MAX_RULES)) begin
                            r_sum[i_rule_label] <= sum_add[rvcs_pkg::SUM_W]
                                ? {rvcs_pkg::SUM_W{1'b1}} : sum_add[rvcs_pkg::SUM_W-1:0];
                            r_count[i_rule_label] <= r_count[i_rule_label] + 1'b1;
                        end
                        if (i_last_rule) begin
                            r_state <= S_MUL;
                            r_cls   <= '0;
                            r_cnt   <= '0;
                            r_prod  <= '0;
                            r_total <= '0;
                        end
                    end
                end
                S_MUL: begin
                    // Shift-add over cost bits, most significant first
                    r_prod <= {r_prod[PW-2:0], 1'b0}
                            + (r_cost[r_cls][4'd15 - r_cnt[3:0]]
                               ? {{(PW - rvcs_pkg::SUM_W){1'b0}}, r_sum[r_cls]} : '0);
                    if (r_cnt == 6'd15) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_sh - div_d : div_sh;
                    if (r_cnt == 6'(PW - 1)) begin
                        // Quotient done; clear the product for the next class
                        r_prod       <= '0;
                        r_raw[r_cls] <= {r_prod[PW-2:0], div_ge};
                        r_total <= r_total + TW'({r_prod[PW-2:0], div_ge});
                        r_cnt   <= '0;
                        if (32'(r_cls) == NC - 1) begin
                            r_cls   <= '0;
                            r_state <= S_NORM;
                        end else begin
                            r_cls   <= r_cls + 2'd1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_prod <= {r_prod[PW-2:0], div_ge};
                        r_cnt  <= r_cnt + 6'd1;
                    end
                end
                S_NORM: begin
                    r_nrem <= norm_ge ? norm_sh - {1'b0, r_total} : norm_sh;
                    r_q    <= {r_q[rvcs_pkg::SCORE_W-2:0], norm_ge};
                    if (r_cnt == 6'(rvcs_pkg::SCORE_W - 1)) begin
                        r_norm[r_cls] <= (r_total == '0) ? '0
                                       : {r_q[rvcs_pkg::SCORE_W-2:0], norm_ge};
                        r_cnt <= '0;
                        if (32'(r_cls) == NC - 1) begin
                            r_cls   <= '0;
                            r_taken <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_cls <= r_cls + 2'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    // One result per cycle: class k score, class at rank k
                    o_valid        <= 1'b1;
                    o_class_index  <= r_cls;
                    o_class_score  <= r_norm[r_cls];
                    o_ranked_label <= best;
                    o_final_result <= (32'(r_cls) == NC - 1);
                    r_taken[best]  <= 1'b1;
                    if (32'(r_cls) == NC - 1) begin
                        r_state <= S_IDLE;
                        for (int i = 0; i < NC; i++) begin
                            r_sum[i]   <= '0;
                            r_count[i] <= '0;
                        end
                    end else begin
                        r_cls <= r_cls + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/rvcs_checker.sv @@
// Port-level checks of the rule vote class scorer, bound to the top level.
module rvcs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_last_rule,
    input logic                          o_valid,
    input logic [rvcs_pkg::LABEL_W-1:0]  o_class_index,
    input logic                          o_final_result
);
    // A last-rule request starts scoring
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_rule) |=> busy)
        else $error("last request did not start scoring");

    // A shown result with the final flag is for the last class
    a_final_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_result && o_valid |-> o_class_index == 2'(rvcs_pkg::NUM_CLASSES - 1))
        else $error("final flag on wrong class");

    // Results of one run come back to back in index order
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_result) |=>
            (o_valid && o_class_index == $past(o_class_index) + 2'd1))
        else $error("result run broken");

    // No result while idle before scoring
    a_no_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_class_index == 2'd0) |-> $past(busy))
        else $error("result without scoring");
endmodule

bind rule_vote_class_scorer rvcs_checker u_rvcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_rule    (i_last_rule),
    .o_valid        (o_valid),
    .o_class_index  (o_class_index),
    .o_final_result (o_final_result)
);

@@ dv/tb_rule_vote_class_scorer.sv @@
// Testbench for the rule vote class scorer: drives rule votes and costs, checks class results.
`timescale 1ns / 1ps

module tb_rule_vote_class_scorer;

    typedef struct packed {
        logic [rvcs_pkg::LABEL_W-1:0] index;
        logic [rvcs_pkg::SCORE_W-1:0] score;
        logic [rvcs_pkg::LABEL_W-1:0] ranked;
        logic                         final_flag;
    } t_class_res;

    // Tracks vote sums and queues the class results each query end should give
    class class_score_board;
        t_class_res pending[$];
        logic [15:0] costs[4];
        logic [63:0] sums[4];
        logic [63:0] counts[4];
        int mismatches;

        function void reset_state();
            for (int i = 0; i < 4; i++) begin
                costs[i] = rvcs_pkg::COST_INIT;
                sums[i] = '0;
                counts[i] = '0;
            end
        endfunction

        function void set_cost(int idx, logic [15:0] val);
            costs[idx] = val;
        endfunction

        // Accepted request: accumulate, and on last rule compute the ranking
        function void note_request(logic pres, logic [1:0] lbl, logic [16:0] conf, logic last);
            logic [63:0] raw[4];
            logic [63:0] norm[4];
            logic [63:0] total;
            logic [63:0] c;
            bit taken[4];
            int rank[4];
            int best;
            t_class_res r;
            if (pres && lbl < rvcs_pkg::NUM_CLASSES && counts[lbl] < rvcs_pkg::MAX_RULES) begin
                c = (conf > rvcs_pkg::CONF_ONE) ? 64'(rvcs_pkg::CONF_ONE) : 64'(conf);
                sums[lbl] = sums[lbl] + c;
                if (sums[lbl] > 64'((1 << rvcs_pkg::SUM_W) - 1))
                    sums[lbl] = 64'((1 << rvcs_pkg::SUM_W) - 1);
                counts[lbl] = counts[lbl] + 64'd1;
            end
            if (!last) return;
            total = '0;
            for (int i = 0; i < rvcs_pkg::NUM_CLASSES; i++) begin
                raw[i] = (64'(costs[i]) * sums[i]) / (counts[i] + 64'd1);
                total += raw[i];
            end
            for (int i = 0; i < rvcs_pkg::NUM_CLASSES; i++) begin
                norm[i] = (total > 0) ? (raw[i] << 16) / total : '0;
                taken[i] = 0;
            end
            for (int k = 0; k < rvcs_pkg::NUM_CLASSES; k++) begin
                best = -1;
                for (int j = 0; j < rvcs_pkg::NUM_CLASSES; j++) begin
                    if (!taken[j] && (best < 0 || norm[j] > norm[best])) best = j;
                end
                taken[best] = 1;
                rank[k] = best;
            end
            for (int k = 0; k < rvcs_pkg::NUM_CLASSES; k++) begin
                r.index = k[1:0];
                r.score = norm[k][16:0];
                r.ranked = rank[k][1:0];
                r.final_flag = (k == rvcs_pkg::NUM_CLASSES - 1);
                pending.push_back(r);
            end
            for (int i = 0; i < 4; i++) begin
                sums[i] = '0;
                counts[i] = '0;
            end
        endfunction

        function void check_result(t_class_res got);
            t_class_res want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic i_vote_present, i_last_rule, i_cfg_we;
    logic [rvcs_pkg::LABEL_W-1:0] i_rule_label;
    logic [rvcs_pkg::CONF_W-1:0] i_rule_confidence;
    logic [1:0] i_cfg_index;
    logic [rvcs_pkg::COST_W-1:0] i_cfg_data;
    logic o_valid, o_final_result;
    logic [rvcs_pkg::LABEL_W-1:0] o_class_index, o_ranked_label;
    logic [rvcs_pkg::SCORE_W-1:0] o_class_score;

    class_score_board board;
    int send_idle_pct;

    rule_vote_class_scorer u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("rule_vote_class_scorer verification failed");
        $finish;
    end

    // Sample results and accepted requests at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                board.check_result({o_class_index, o_class_score, o_ranked_label,
                                    o_final_result});
            if (start && !busy)
                board.note_request(i_vote_present, i_rule_label, i_rule_confidence,
                                   i_last_rule);
        end
    end

    // One request: random idle gap, then hold start until accepted.
    // Returns right after the accepting edge; start is dropped by the next driver.
    task automatic send_request(logic pres, logic [1:0] lbl, logic [16:0] conf, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_vote_present <= pres;
        i_rule_label <= lbl;
        i_rule_confidence <= conf;
        i_last_rule <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (320) @(negedge i_clk);
    endtask

    task automatic write_cost(int idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx[1:0];
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_cost(idx, val);
        @(negedge i_clk);
    endtask

    // Random query of a few rule votes
    task automatic random_query();
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            send_request($urandom_range(9) != 0, 2'($urandom_range(3)),
                         ($urandom_range(7) == 0) ? 17'($urandom_range(131071))
                                                  : 17'($urandom_range(65536)), 1'b0);
        end
        send_request($urandom_range(3) != 0, 2'($urandom_range(3)),
                     17'($urandom_range(131071)), 1'b1);
    endtask

    initial begin
        board = new();
        board.reset_state();
        send_idle_pct = 0;
        start = 0; i_vote_present = 0; i_rule_label = 0; i_rule_confidence = 0;
        i_last_rule = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty query, extremes, clamping, ties, no-vote items
        send_request(1'b0, 2'd0, 17'd0, 1'b1);
        send_request(1'b1, 2'd0, 17'd65536, 1'b0);
        send_request(1'b1, 2'd1, 17'd131071, 1'b0);
        send_request(1'b0, 2'd2, 17'd5, 1'b0);
        send_request(1'b1, 2'd3, 17'd0, 1'b1);
        send_request(1'b1, 2'd2, 17'd65536, 1'b0);
        send_request(1'b1, 2'd3, 17'd65536, 1'b1);
        send_request(1'b1, 2'd1, 17'd1, 1'b1);
        wait_idle();
        write_cost(0, 16'hFFFF);
        write_cost(1, 16'h0000);
        write_cost(2, 16'h0001);
        write_cost(3, 16'h8000);
        for (int i = 0; i < 4; i++) send_request(1'b1, i[1:0], 17'h1FFFF, i == 3);
        send_request(1'b1, 2'd0, 17'd0, 1'b0);
        send_request(1'b0, 2'd0, 17'd0, 1'b1);
        wait_idle();

        // Random phases under different idle rates and cost settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 76;
                2: send_idle_pct = 0;
                default: send_idle_pct = 35;
            endcase
            wait_idle();
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(3))
                    0: write_cost(i, 16'h0000);
                    1: write_cost(i, 16'hFFFF);
                    default: write_cost(i, 16'($urandom_range(65535)));
                endcase
            end
            for (int q = 0; q < 8; q++) begin
                random_query();
            end
        end
        wait_idle();
        if (board.mismatches == 0) begin
            $display("rule_vote_class_scorer verification clean");
        end else begin
            $display("rule_vote_class_scorer verification failed");
        end
        $finish;
    end
endmodule
